// File: src/sbf_pkg.sv
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared types and constants of the sectorized Bloom filter probe.
// ----------------------------------------------------------------------------
package sbf_pkg;

  localparam int unsigned FilterWordsDefault = 65536;
  // widest word index that the hash can form (17 low bits + 9 high bits)
  localparam int unsigned MaxAddrW           = 26;
  localparam int unsigned CmdDepth           = 4;
  localparam int unsigned OutDepth           = 4;
  localparam int unsigned SizeW              = 5;
  localparam logic [SizeW-1:0] SizeLog2Reset = 5'd16;
  localparam logic [SizeW-1:0] SizeLog2Min   = 5'd4;

  typedef enum logic {
    CmdLoad  = 1'b0,
    CmdProbe = 1'b1
  } cmd_e;

  // one command word between front and back
  typedef struct packed {
    cmd_e                cmd;
    logic [MaxAddrW-1:0] addr_a;
    logic [MaxAddrW-1:0] addr_b;
    logic [31:0]         data;
    logic [14:0]         pos_a;
    logic [19:0]         pos_b;
    logic                last;
  } cmd_item_t;

  typedef struct packed {
    logic        is_hit;
    logic [31:0] hit_count;
    logic        batch_end;
  } result_t;

  // one-hot bit of a 32-bit word from a 5-bit position
  function automatic logic [31:0] bit_mask(input logic [4:0] pos);
    bit_mask = 32'd1 << pos;
  endfunction

endpackage

// File: src/sbf_ram.sv
// ----------------------------------------------------------------------------
// sbf_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module sbf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: src/sbf_fifo.sv
// ----------------------------------------------------------------------------
// sbf_fifo
// Small flop-based queue with level output.
// ----------------------------------------------------------------------------
module sbf_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned LvlW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o,
  output logic [LvlW-1:0]  level_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0]  level_q, level_d;
  logic             do_push, do_pop;

  assign full_o  = (level_q == LvlW'(Depth));
  assign empty_o = (level_q == '0);
  assign level_o = level_q;
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   level_d = level_q + 1'b1;
      2'b01:   level_d = level_q - 1'b1;
      default: level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: src/sbf_front.sv
// ----------------------------------------------------------------------------
// sbf_front
// Accepts commands, holds the size register and forms word indices and
// mask bit positions for probes.
// ----------------------------------------------------------------------------
module sbf_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [sbf_pkg::SizeW-1:0] cfg_data_i,
  input  logic                     push_i,
  input  logic                     full_i,
  input  logic                     command_i,
  input  logic [15:0]              word_index_i,
  input  logic [31:0]              word_data_i,
  input  logic [63:0]              key_hash_i,
  input  logic                     last_in_batch_i,
  output logic                     push_o,
  output sbf_pkg::cmd_item_t       item_o
);

  logic [sbf_pkg::SizeW-1:0]    size_log2_q, size_log2_d;
  logic [sbf_pkg::SizeW-1:0]    size_eff;
  logic [sbf_pkg::MaxAddrW-1:0] size_mask;
  logic [sbf_pkg::MaxAddrW-1:0] w1;
  logic [31:0]                  lo, hi;

  assign cfg_ready_o = 1'b1;
  assign push_o      = push_i & ~full_i;

  assign size_log2_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : size_log2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= sbf_pkg::SizeLog2Reset;
    end else begin
      size_log2_q <= size_log2_d;
    end
  end

  assign lo = key_hash_i[31:0];
  assign hi = key_hash_i[63:32];

  always_comb begin
    size_eff = (size_log2_q < sbf_pkg::SizeLog2Min) ? sbf_pkg::SizeLog2Min : size_log2_q;
    if (size_eff >= sbf_pkg::SizeW'(sbf_pkg::MaxAddrW)) begin
      size_mask = '1;
    end else begin
      size_mask = ~({sbf_pkg::MaxAddrW{1'b1}} << size_eff);
    end
    // low 17 bits and the 9 upper bits never overlap, so the add is a concat
    w1 = {hi[11:3], lo[16:0]} & size_mask;
  end

  always_comb begin
    item_o = '0;
    case (sbf_pkg::cmd_e'(command_i))
      sbf_pkg::CmdLoad: begin
        item_o.cmd    = sbf_pkg::CmdLoad;
        item_o.addr_a = sbf_pkg::MaxAddrW'(word_index_i);
        item_o.data   = word_data_i;
      end
      sbf_pkg::CmdProbe: begin
        item_o.cmd    = sbf_pkg::CmdProbe;
        item_o.addr_a = w1;
        item_o.addr_b = w1 ^ sbf_pkg::MaxAddrW'({1'b1, hi[2:0]});
        item_o.pos_a  = {lo[31:27], lo[26:22], lo[21:17]};
        item_o.pos_b  = {hi[31:27], hi[26:22], hi[21:17], hi[16:12]};
        item_o.last   = last_in_batch_i;
      end
      default: item_o = '0;
    endcase
  end

endmodule

// File: src/sbf_back.sv
// ----------------------------------------------------------------------------
// sbf_back
// Executes queued commands: loads write the filter, probes read two words,
// test the masks and keep the batch hit count.
// ----------------------------------------------------------------------------
module sbf_back #(
  parameter int unsigned FilterWords = sbf_pkg::FilterWordsDefault,
  parameter int unsigned OutDepth    = sbf_pkg::OutDepth,
  localparam int unsigned AddrW = $clog2(FilterWords),
  localparam int unsigned LvlW  = $clog2(OutDepth + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  sbf_pkg::cmd_item_t cmd_item_i,
  output logic               cmd_pop_o,
  input  logic [LvlW-1:0]    out_level_i,
  output logic               out_push_o,
  output sbf_pkg::result_t   out_result_o
);

  logic              room;
  logic              is_probe;
  logic              probe_go;
  logic              load_go;
  logic              b_valid_q;
  logic [14:0]       b_pos_a_q;
  logic [19:0]       b_pos_b_q;
  logic              b_last_q;
  logic [31:0]       rdata_a, rdata_b;
  logic [31:0]       mask_a, mask_b;
  logic              hit;
  logic [31:0]       count_inc;
  logic [31:0]       hits_q, hits_d;

  // a probe in flight already owns one output slot
  assign room     = ((LvlW + 1)'(out_level_i) + (LvlW + 1)'(b_valid_q)) <
                    (LvlW + 1)'(OutDepth);
  assign is_probe = (cmd_item_i.cmd == sbf_pkg::CmdProbe);
  assign cmd_pop_o = cmd_valid_i && (!is_probe || room);
  assign probe_go = cmd_pop_o && is_probe;
  assign load_go  = cmd_pop_o && !is_probe;

  sbf_ram #(
    .Width (32),
    .Depth (FilterWords)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (load_go),
    .waddr_i   (cmd_item_i.addr_a[AddrW-1:0]),
    .wdata_i   (cmd_item_i.data),
    .re_i      (probe_go),
    .raddr_a_i (cmd_item_i.addr_a[AddrW-1:0]),
    .raddr_b_i (cmd_item_i.addr_b[AddrW-1:0]),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= probe_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (probe_go) begin
      b_pos_a_q <= cmd_item_i.pos_a;
      b_pos_b_q <= cmd_item_i.pos_b;
      b_last_q  <= cmd_item_i.last;
    end
  end

  always_comb begin
    mask_a = sbf_pkg::bit_mask(b_pos_a_q[4:0]) | sbf_pkg::bit_mask(b_pos_a_q[9:5]) |
             sbf_pkg::bit_mask(b_pos_a_q[14:10]);
    mask_b = sbf_pkg::bit_mask(b_pos_b_q[4:0]) | sbf_pkg::bit_mask(b_pos_b_q[9:5]) |
             sbf_pkg::bit_mask(b_pos_b_q[14:10]) | sbf_pkg::bit_mask(b_pos_b_q[19:15]);
    hit    = ((rdata_a & mask_a) == mask_a) && ((rdata_b & mask_b) == mask_b);
    // saturating count
    count_inc = (hit && (hits_q != '1)) ? hits_q + 32'd1 : hits_q;
    hits_d    = hits_q;
    if (b_valid_q) begin
      hits_d = b_last_q ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q <= '0;
    end else begin
      hits_q <= hits_d;
    end
  end

  assign out_push_o             = b_valid_q;
  assign out_result_o.is_hit    = hit;
  assign out_result_o.hit_count = count_inc;
  assign out_result_o.batch_end = b_last_q;

endmodule

// File: src/sectorized_bloom_filter_probe.sv
// ----------------------------------------------------------------------------
// sectorized_bloom_filter_probe
// Sectorized Bloom filter: load filter words, probe 64-bit key hashes.
// ----------------------------------------------------------------------------
// Input side is a queue: a word is taken when push is high and full is low.
// command_i = 0 loads word_data_i at word_index_i, command_i = 1 probes
// key_hash_i. Loads give no result; each probe gives one result word.
// Result side is a queue: while empty is low the oldest result sits on
// is_hit_o, hit_count_o and batch_end_o, and pop takes it.
// size_log2 is written over cfg_valid_i/cfg_data_i (cfg_ready_o is always
// high); write it only while the block is idle, the block does not enforce this.
// A probe passes through the command queue, then the registered read of the
// filter RAM, and then enters the result queue.
// Throughput: one command per cycle while the result queue has room; the two filter words of a probe come
// from the two read ports of the filter RAM in the same cycle.
// Reset clears the queues, the batch hit count and sets size_log2 to 16;
// filter contents are not cleared and must be loaded before they are probed.
// When pop stays low the result queue (4 words) fills, the back end stops,
// the command queue (4 words) fills and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module sectorized_bloom_filter_probe #(
  parameter int unsigned FilterWords = sbf_pkg::FilterWordsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sbf_pkg::SizeW-1:0] cfg_data_i,
  input  logic                      push,
  output logic                      full,
  input  logic                      command_i,
  input  logic [15:0]               word_index_i,
  input  logic [31:0]               word_data_i,
  input  logic [63:0]               key_hash_i,
  input  logic                      last_in_batch_i,
  output logic                      empty,
  input  logic                      pop,
  output logic                      is_hit_o,
  output logic [31:0]               hit_count_o,
  output logic                      batch_end_o
);

  localparam int unsigned CmdW     = $bits(sbf_pkg::cmd_item_t);
  localparam int unsigned ResW     = $bits(sbf_pkg::result_t);
  localparam int unsigned OutLvlW  = $clog2(sbf_pkg::OutDepth + 1);
  localparam int unsigned CmdLvlW  = $clog2(sbf_pkg::CmdDepth + 1);

  logic               cmd_push;
  sbf_pkg::cmd_item_t cmd_in;
  sbf_pkg::cmd_item_t cmd_head;
  logic               cmd_empty;
  logic               cmd_pop;
  logic [CmdLvlW-1:0] cmd_level;
  logic               out_push;
  logic               out_full;
  logic [OutLvlW-1:0] out_level;
  sbf_pkg::result_t   out_in;
  sbf_pkg::result_t   out_head;

  sbf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .push_i          (push),
    .full_i          (full),
    .command_i       (command_i),
    .word_index_i    (word_index_i),
    .word_data_i     (word_data_i),
    .key_hash_i      (key_hash_i),
    .last_in_batch_i (last_in_batch_i),
    .push_o          (cmd_push),
    .item_o          (cmd_in)
  );

  sbf_fifo #(
    .Width (CmdW),
    .Depth (sbf_pkg::CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .full_o  (full),
    .empty_o (cmd_empty),
    .level_o (cmd_level)
  );

  sbf_back #(
    .FilterWords (FilterWords),
    .OutDepth    (sbf_pkg::OutDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (!cmd_empty),
    .cmd_item_i   (cmd_head),
    .cmd_pop_o    (cmd_pop),
    .out_level_i  (out_level),
    .out_push_o   (out_push),
    .out_result_o (out_in)
  );

  sbf_fifo #(
    .Width (ResW),
    .Depth (sbf_pkg::OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_in),
    .pop_i   (pop),
    .data_o  (out_head),
    .full_o  (out_full),
    .empty_o (empty),
    .level_o (out_level)
  );

  assign is_hit_o    = out_head.is_hit;
  assign hit_count_o = out_head.hit_count;
  assign batch_end_o = out_head.batch_end;

  // the back end never writes a result into a full result queue
  a_no_out_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("result queue overflow");

  // commands are only taken from a non-empty queue
  a_cmd_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("pop from empty command queue");

  // command queue level stays within its depth
  a_cmd_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_level <= CmdLvlW'(sbf_pkg::CmdDepth))
    else $error("command queue level out of range");

  // exactly the probes taken by the back end produce a result in the following cycle
  a_probe_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (out_push == $past(cmd_pop && (cmd_head.cmd == sbf_pkg::CmdProbe))))
    else $error("result does not match issued probe");

endmodule
